// ----- rtl/slc_pkg.sv -----
// shared constants, item and line types for the cache lookup block
package slc_pkg;

    localparam int ADDR_W       = 32;
    localparam int MAX_SET_BITS = 6;
    localparam int WAYS         = 8;
    localparam int NUM_SETS     = 1 << MAX_SET_BITS;
    localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W         = $clog2(WAYS + 1);
    localparam int TAG_W        = ADDR_W;
    localparam int STAMP_W      = 32;
    localparam int CNT_W        = 32;

    // configuration register widths
    localparam int SB_W         = 3;
    localparam int BB_W         = 5;
    localparam int NWCFG_W      = 4;
    localparam int SHIFT_W      = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    // command queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        logic [NW_W-1:0]  nw;
    } t_item;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_line;

    typedef t_line [WAYS-1:0] t_row;

endpackage

// ----- rtl/set_assoc_lru_cache_lookup_core.sv -----
// top level of the set associative lru cache lookup
//
// usage:
// - one word per lookup: drive i_address with start high; it is taken on a
//   clock edge where busy is low
// - the front decodes the address into set index and tag with the current
//   set and block bit counts and pushes a command into a two-entry queue
// - the back pops a command, reads the whole set row (all ways) from the set
//   memory into a register, then matches tags, picks the lru way and writes the
//   row back in the next cycle
// - the back takes one word at a time (row read, then row write back); the
//   front keeps queueing words while there is room; registered o_valid is
//   high for one cycle; the receiver cannot stall, so every result is shown once
// - counts on o_*_count saturate and stay stable between results
// - configuration: i_cfg_we with i_cfg_idx (0 set bits, 1 block bits,
//   2 ways in use) and i_cfg_wdata; write only while no lookup is in flight
// - reset: synchronous, active low; after reset a clearing pass (one set row
//   per cycle, 64 rows) zeroes the valid bits, busy stays high meanwhile
module set_assoc_lru_cache_lookup_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  logic [slc_pkg::ADDR_W-1:0]     i_address,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [slc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [slc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // result channel
    output logic                           o_valid,
    output logic                           o_hit,
    output logic                           o_evicted,
    output logic [slc_pkg::WAY_W-1:0]      o_way_used,
    output logic [slc_pkg::CNT_W-1:0]      o_hit_count,
    output logic [slc_pkg::CNT_W-1:0]      o_miss_count,
    output logic [slc_pkg::CNT_W-1:0]      o_eviction_count
);
    import slc_pkg::*;

    // front to queue
    logic  push;
    t_item push_item;
    // queue to back
    logic  q_empty, q_full, pop;
    t_item q_head;
    // back status, high during the post-reset clearing pass
    logic  clearing;

    slc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_start     (start),
        .i_address   (i_address),
        .i_clearing  (clearing),
        .i_q_full    (q_full),
        .o_busy      (busy),
        .o_push      (push),
        .o_item      (push_item)
    );

    // decouples decode from lookup so each side stalls on its own
    slc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    // set memory, lookup, replacement and counters
    slc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_head         (q_head),
        .o_pop            (pop),
        .o_clearing       (clearing),
        .o_valid          (o_valid),
        .o_hit            (o_hit),
        .o_evicted        (o_evicted),
        .o_way_used       (o_way_used),
        .o_hit_count      (o_hit_count),
        .o_miss_count     (o_miss_count),
        .o_eviction_count (o_eviction_count)
    );

endmodule

// ----- rtl/slc_front.sv -----
// front end: configuration registers, address decode and command push
module slc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [slc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [slc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_start,
    input  logic [slc_pkg::ADDR_W-1:0]     i_address,
    input  logic                           i_clearing,
    input  logic                           i_q_full,
    output logic                           o_busy,
    output logic                           o_push,
    output slc_pkg::t_item                 o_item
);
    import slc_pkg::*;

    logic [SB_W-1:0]    r_set_bits;
    logic [BB_W-1:0]    r_block_bits;
    logic [NWCFG_W-1:0] r_ways;

    logic [SB_W-1:0]    sb;
    logic [SHIFT_W-1:0] tag_shift;
    logic [ADDR_W-1:0]  set_shifted;
    logic [SET_W-1:0]   set_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= SB_W'(4);
            r_block_bits <= BB_W'(4);
            r_ways       <= NWCFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SET_BITS:   r_set_bits   <= i_cfg_wdata[SB_W-1:0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_wdata[BB_W-1:0];
                CFG_WAYS:       r_ways       <= i_cfg_wdata[NWCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp set bits, split the address
    always_comb begin
        sb          = (int'(r_set_bits) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : r_set_bits;
        tag_shift   = SHIFT_W'(r_block_bits) + SHIFT_W'(sb);
        set_shifted = i_address >> r_block_bits;
        set_mask    = ~({SET_W{1'b1}} << sb);

        o_item.set_idx = set_shifted[SET_W-1:0] & set_mask;
        o_item.tag     = TAG_W'(i_address >> tag_shift);
        if (r_ways == '0) begin
            o_item.nw = NW_W'(1);
        end else if (int'(r_ways) > WAYS) begin
            o_item.nw = NW_W'(WAYS);
        end else begin
            o_item.nw = NW_W'(r_ways);
        end
    end

    assign o_busy = i_clearing | i_q_full;
    assign o_push = i_start & ~o_busy;

endmodule

// ----- rtl/slc_queue.sv -----
// small command queue between decode and lookup
module slc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  slc_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_empty,
    output logic           o_full,
    output slc_pkg::t_item o_head
);
    import slc_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_item;
    end

endmodule

// ----- rtl/slc_back.sv -----
// back end: set memory, tag match, lru pick, line update and counters
module slc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  slc_pkg::t_item              i_q_head,
    output logic                        o_pop,
    output logic                        o_clearing,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic                        o_evicted,
    output logic [slc_pkg::WAY_W-1:0]   o_way_used,
    output logic [slc_pkg::CNT_W-1:0]   o_hit_count,
    output logic [slc_pkg::CNT_W-1:0]   o_miss_count,
    output logic [slc_pkg::CNT_W-1:0]   o_eviction_count
);
    import slc_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;

    t_row               r_mem [NUM_SETS];
    t_row               r_rdata;
    t_item              r_item;
    logic [1:0]         r_state, n_state;
    logic [SET_W-1:0]   r_clr_idx, n_clr_idx;
    logic [STAMP_W-1:0] r_stamp;
    logic [CNT_W-1:0]   r_hits, r_misses, r_evicts;
    logic               r_out_valid;
    logic               r_hit, r_evicted;
    logic [WAY_W-1:0]   r_way;

    logic               wr_en;
    logic [SET_W-1:0]   wr_addr;
    t_row               wr_row;
    logic               eval;

    logic [WAYS-1:0]    in_use, stop, is_lru;
    logic               found, hit, evict;
    logic [WAY_W-1:0]   first_way, lru_way, way;
    logic [STAMP_W-1:0] new_stamp;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // way search over the registered set row
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            in_use[w] = (NW_W'(w) < r_item.nw);
            stop[w]   = in_use[w] &&
                        (!r_rdata[w].valid || (r_rdata[w].tag == r_item.tag));
        end
        // lru: strictly older than lower ways, not newer than higher ways
        for (int w = 0; w < WAYS; w++) begin
            is_lru[w] = in_use[w];
            for (int v = 0; v < WAYS; v++) begin
                if (v < w && in_use[v] && !(r_rdata[w].stamp < r_rdata[v].stamp)) begin
                    is_lru[w] = 1'b0;
                end
                if (v > w && in_use[v] && (r_rdata[w].stamp > r_rdata[v].stamp)) begin
                    is_lru[w] = 1'b0;
                end
            end
        end
        found     = 1'b0;
        first_way = '0;
        lru_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (stop[w]) begin
                found     = 1'b1;
                first_way = WAY_W'(w);
            end
            if (is_lru[w]) lru_way = WAY_W'(w);
        end
        way       = found ? first_way : lru_way;
        hit       = found && r_rdata[first_way].valid;
        evict     = !found;
        new_stamp = r_stamp + 1'b1;
    end

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        o_pop     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_item.set_idx;
        wr_row    = r_rdata;
        eval      = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                wr_en     = 1'b1;
                wr_addr   = r_clr_idx;
                wr_row    = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == SET_W'(NUM_SETS - 1)) n_state = ST_READ;
            end
            ST_READ: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                eval              = 1'b1;
                wr_en             = 1'b1;
                wr_row[way].valid = 1'b1;
                wr_row[way].tag   = r_item.tag;
                wr_row[way].stamp = new_stamp;
                n_state           = ST_READ;
            end
            default: n_state = ST_READ;
        endcase
    end

    // set memory, read data registered
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_row;
        if (o_pop) begin
            r_rdata <= r_mem[i_q_head.set_idx];
            r_item  <= i_q_head;
        end
        if (eval) begin
            r_hit     <= hit;
            r_evicted <= evict;
            r_way     <= way;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_stamp     <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= eval;
            if (eval) begin
                r_stamp <= new_stamp;
                if (hit) begin
                    r_hits <= sat_inc(r_hits);
                end else begin
                    r_misses <= sat_inc(r_misses);
                    if (evict) r_evicts <= sat_inc(r_evicts);
                end
            end
        end
    end

    assign o_clearing       = (r_state == ST_CLEAR);
    assign o_valid          = r_out_valid;
    assign o_hit            = r_hit;
    assign o_evicted        = r_evicted;
    assign o_way_used       = r_way;
    assign o_hit_count      = r_hits;
    assign o_miss_count     = r_misses;
    assign o_eviction_count = r_evicts;

endmodule

// ----- bench/tb_set_assoc_lru_cache_lookup_core.sv -----
// self-checking testbench for the set associative lru cache lookup core
module tb_set_assoc_lru_cache_lookup_core;

    import slc_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT   = 100000;
    localparam int RAND_PHASES   = 13;
    localparam int PHASE_WORDS   = 100;
    localparam int QUIET_PHASES  = 2;     // last phases run without idling
    localparam int SETTLE_CYCLES = 6;     // result strobe is registered after the set row read
    localparam int MAX_REPORTS   = 20;

    // what one lookup word should produce
    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [WAY_W-1:0] way;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evictions;
    } t_lookup_outcome;

    // mirror of the cache: predicts each lookup and checks the result stream
    class lru_lookup_tracker;
        logic [SB_W-1:0]    cfg_set_bits;
        logic [BB_W-1:0]    cfg_block_bits;
        logic [NWCFG_W-1:0] cfg_ways;

        logic               valid_mem [NUM_SETS*WAYS];
        logic [TAG_W-1:0]   tag_mem   [NUM_SETS*WAYS];
        logic [STAMP_W-1:0] stamp_mem [NUM_SETS*WAYS];
        logic [STAMP_W-1:0] stamp_now;
        logic [CNT_W-1:0]   hit_tally, miss_tally, evict_tally;

        t_lookup_outcome    pending_outcomes [$];
        int                 errors;
        int                 lookups, config_writes;

        function new();
            cfg_set_bits   = 3'd4;
            cfg_block_bits = 5'd4;
            cfg_ways       = 4'd1;
            foreach (valid_mem[k]) begin
                valid_mem[k] = 1'b0;
                tag_mem[k]   = '0;
                stamp_mem[k] = '0;
            end
            stamp_now   = '0;
            hit_tally   = '0;
            miss_tally  = '0;
            evict_tally = '0;
            errors        = 0;
            lookups       = 0;
            config_writes = 0;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            config_writes++;
            case (idx)
                CFG_SET_BITS:   cfg_set_bits   = data[SB_W-1:0];
                CFG_BLOCK_BITS: cfg_block_bits = data[BB_W-1:0];
                CFG_WAYS:       cfg_ways       = data[NWCFG_W-1:0];
                default: ;
            endcase
        endfunction

        // accepted lookup word: search the set, update lines and counts
        function void note_lookup(logic [ADDR_W-1:0] addr);
            int unsigned     sbe, nwe, base, w, lru, k;
            logic [63:0]     a64, set_idx, tag;
            logic            found;
            t_lookup_outcome o;
            sbe = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
            nwe = (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS) ? WAYS : cfg_ways);
            // bits past the address read as zero
            a64     = {{(64-ADDR_W){1'b0}}, addr};
            set_idx = (a64 >> cfg_block_bits) & ((64'd1 << sbe) - 64'd1);
            tag     = a64 >> (cfg_block_bits + sbe);
            base    = 32'(set_idx) * WAYS;
            lru     = 0;
            found   = 1'b0;
            o       = '0;
            for (w = 0; w < nwe; w++) begin
                k = base + w;
                if (!valid_mem[k]) begin
                    o.way = WAY_W'(w);
                    found = 1'b1;
                    break;
                end
                if (tag_mem[k] == tag[TAG_W-1:0]) begin
                    o.way = WAY_W'(w);
                    o.hit = 1'b1;
                    found = 1'b1;
                    break;
                end
                // strict compare keeps the lowest way on a tie
                if (w == 0 || stamp_mem[k] < stamp_mem[base + lru]) lru = w;
            end
            if (!found) begin
                o.way     = WAY_W'(lru);
                o.evicted = 1'b1;
            end
            stamp_now++;
            valid_mem[base + o.way] = 1'b1;
            tag_mem[base + o.way]   = tag[TAG_W-1:0];
            stamp_mem[base + o.way] = stamp_now;
            if (o.hit) begin
                if (hit_tally != '1) hit_tally++;
            end else begin
                if (miss_tally != '1) miss_tally++;
                if (o.evicted && evict_tally != '1) evict_tally++;
            end
            o.hits      = hit_tally;
            o.misses    = miss_tally;
            o.evictions = evict_tally;
            pending_outcomes.push_back(o);
            lookups++;
        endfunction

        function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic hit, logic evicted, logic [WAY_W-1:0] way,
                                   logic [CNT_W-1:0] hits, logic [CNT_W-1:0] misses,
                                   logic [CNT_W-1:0] evictions);
            t_lookup_outcome want;
            if (pending_outcomes.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t unexpected result word: expected none, got hit %0b way %0d",
                             $time, hit, way);
                return;
            end
            want = pending_outcomes.pop_front();
            compare_field("hit", CNT_W'(want.hit), CNT_W'(hit));
            compare_field("evicted", CNT_W'(want.evicted), CNT_W'(evicted));
            compare_field("way_used", CNT_W'(want.way), CNT_W'(way));
            compare_field("hit_count", want.hits, hits);
            compare_field("miss_count", want.misses, misses);
            compare_field("eviction_count", want.evictions, evictions);
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction
    endclass

    // every input known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic [ADDR_W-1:0]     i_address   = '0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = CFG_SET_BITS;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    logic                  busy;
    logic                  o_valid;
    logic                  o_hit;
    logic                  o_evicted;
    logic [WAY_W-1:0]      o_way_used;
    logic [CNT_W-1:0]      o_hit_count;
    logic [CNT_W-1:0]      o_miss_count;
    logic [CNT_W-1:0]      o_eviction_count;

    lru_lookup_tracker tracker;
    int unsigned       cycles = 0;
    int                settings_seen = 0;

    set_assoc_lru_cache_lookup_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_address        (i_address),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_hit            (o_hit),
        .o_evicted        (o_evicted),
        .o_way_used       (o_way_used),
        .o_hit_count      (o_hit_count),
        .o_miss_count     (o_miss_count),
        .o_eviction_count (o_eviction_count)
    );

    always #1 i_clk = ~i_clk;

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     tracker.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // sample what the block saw at each edge: register writes, accepted
    // words and result strobes; all values read here are pre-edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) tracker.note_config(i_cfg_idx, i_cfg_wdata);
            if (start && !busy) tracker.note_lookup(i_address);
            if (o_valid)
                tracker.check_result(o_hit, o_evicted, o_way_used, o_hit_count,
                                     o_miss_count, o_eviction_count);
        end
    end

    // hold one lookup word until an edge with busy low takes it
    task automatic send_lookup(input logic [ADDR_W-1:0] addr);
        start     <= 1'b1;
        i_address <= addr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // sender gap, address bus left with junk
    task automatic idle_cycles(input int n);
        start     <= 1'b0;
        i_address <= $urandom;
        repeat (n) @(posedge i_clk);
    endtask

    // stop sending and wait for every result already due, then settle
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= CFG_DATA_W'(value);
        @(posedge i_clk);
    endtask

    // new setting only with the block idle; lines stay from the last one
    task automatic set_config(input int unsigned sb, input int unsigned bb,
                              input int unsigned nw);
        drain();
        write_reg(CFG_SET_BITS, sb);
        write_reg(CFG_BLOCK_BITS, bb);
        write_reg(CFG_WAYS, nw);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_seen++;
    endtask

    // one random phase: a small working set of tags spread over a few sets so
    // that fills, hits and lru evictions all happen, plus some noise words
    task automatic random_phase(input int unsigned sb, input int unsigned bb,
                                input int unsigned nw, input int words, input bit gaps);
        int unsigned sbe, nwe, n_sets, n_tags, si, ti, pick;
        int unsigned set_pool [3];
        logic [63:0] tag_pool [16];
        logic [63:0] a64, off_mask;
        int          i;
        sbe      = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
        nwe      = (nw == 0) ? 1 : ((nw > WAYS) ? WAYS : nw);
        n_sets   = $urandom_range(1, 3);
        n_tags   = $urandom_range(1, (nwe + 4 > 16) ? 16 : nwe + 4);
        off_mask = (64'd1 << bb) - 64'd1;
        for (i = 0; i < 3; i++) set_pool[i] = $urandom_range(0, (1 << sbe) - 1);
        for (i = 0; i < 16; i++) tag_pool[i] = {32'd0, $urandom};
        for (i = 0; i < words; i++) begin
            if (gaps && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 6));
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                si  = $urandom_range(0, n_sets - 1);
                ti  = $urandom_range(0, n_tags - 1);
                a64 = (tag_pool[ti] << (bb + sbe)) | (64'(set_pool[si]) << bb) |
                      ({32'd0, $urandom} & off_mask);
                send_lookup(a64[ADDR_W-1:0]);
            end else begin
                send_lookup($urandom);
            end
        end
    endtask

    initial begin
        int unsigned sb, bb, nw;
        int          p, k;
        tracker = new();

        // synchronous reset, then the valid clearing pass keeps busy high
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // reset setting: 16 sets, 16-byte lines, direct mapped
        send_lookup(32'h0000_0000);     // cold fill
        send_lookup(32'h0000_000F);     // same line, other offset: hit
        send_lookup(32'h0000_0100);     // same set, new tag: replaces
        send_lookup(32'hFFFF_FFFF);     // all ones, top set
        send_lookup(32'h0000_0000);     // replaces again

        // one set, byte lines, two ways: lru order
        set_config(0, 0, 2);
        send_lookup(32'h1);
        send_lookup(32'h2);
        send_lookup(32'h1);
        send_lookup(32'h3);
        send_lookup(32'h2);

        // set bits above the limit, widest offset, zero ways
        set_config(7, 31, 0);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(32'h7FFF_FFFF);
        send_lookup(32'h8000_0000);

        // ways above the limit: fill a full row, then one more tag replaces
        set_config(MAX_SET_BITS, 20, 15);
        for (k = 0; k <= WAYS; k++) send_lookup(ADDR_W'(k) << 26);
        send_lookup(32'h0);

        // random phases, the first few pinned to extremes
        for (p = 0; p < RAND_PHASES; p++) begin
            sb = $urandom_range(0, 7);
            bb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 12);
            nw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, WAYS);
            case (p)
                0: begin sb = MAX_SET_BITS; bb = 0;  nw = WAYS; end
                1: begin sb = 0;            bb = 25; nw = 1;    end
                2: begin sb = 7;            bb = 31; nw = 15;   end
                3: begin sb = 1;            bb = 2;  nw = WAYS; end
                default: ;
            endcase
            set_config(sb, bb, nw);
            random_phase(sb, bb, nw, PHASE_WORDS,
                         (p < RAND_PHASES - QUIET_PHASES) && (p % 3 != 0));
        end

        drain();
        $display("covered %0d lookups over %0d settings plus the reset one", tracker.lookups,
                 settings_seen);
        $display("hits %0d, misses %0d, evictions %0d, register writes %0d",
                 tracker.hit_tally, tracker.miss_tally, tracker.evict_tally,
                 tracker.config_writes);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
